// File: sv/jwcs_pkg.sv
`timescale 1ns / 1ps

package jwcs_pkg;

  // Character codes the lexer looks for.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChNul    = 8'h00;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Lexer modes, one-hot.
  typedef enum logic [5:0] {
    MODE_NORMAL     = 6'b000001,
    MODE_STR        = 6'b000010,
    MODE_STR_ESC    = 6'b000100,
    MODE_LINE       = 6'b001000,
    MODE_BLOCK      = 6'b010000,
    MODE_BLOCK_STAR = 6'b100000
  } mode_e;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       last_of_run;
  } out_word_t;

  // One queue entry: every result that one input word causes.
  typedef struct packed {
    logic [7:0] byte0;
    logic       has0;
    logic [7:0] byte1;
    logic       two;
    logic       eot;
  } entry_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// File: sv/jwcs_front.sv
`timescale 1ns / 1ps

module jwcs_front import jwcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_word_t word_i,
  output logic     push_o,
  output entry_t   entry_o
);

  mode_e mode_q, mode_d;
  logic  slash_q, slash_d;

  logic [7:0] b;
  logic       is_end;
  logic       is_space;
  logic       emit_pre;
  logic       emit_byte;
  logic       emit_end_slash;
  logic       emit_bare;

  assign b        = word_i.data_byte;
  assign is_end   = (b == ChNul) || word_i.last;
  assign is_space = (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);

  // Classify the word under the current mode and pick the next mode.
  always_comb begin
    mode_d         = mode_q;
    slash_d        = slash_q;
    emit_pre       = 1'b0;
    emit_byte      = 1'b0;
    emit_end_slash = 1'b0;
    emit_bare      = 1'b0;
    if (b != ChNul) begin
      case (mode_q)
        MODE_STR: begin
          emit_byte = 1'b1;
          if (b == ChBslash) begin
            mode_d = MODE_STR_ESC;
          end else if (b == ChQuote) begin
            mode_d = MODE_NORMAL;
          end
        end
        MODE_STR_ESC: begin
          emit_byte = 1'b1;
          mode_d    = MODE_STR;
        end
        MODE_LINE: begin
          if (b == ChLf) mode_d = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (b == ChStar) mode_d = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == ChSlash) begin
            mode_d = MODE_NORMAL;
          end else if (b != ChStar) begin
            mode_d = MODE_BLOCK;
          end
        end
        default: begin
          mode_d  = MODE_NORMAL;
          slash_d = 1'b0;
          if (slash_q && (b == ChSlash)) begin
            mode_d = MODE_LINE;
          end else if (slash_q && (b == ChStar)) begin
            mode_d = MODE_BLOCK;
          end else begin
            // A held slash that opens no comment is released first.
            emit_pre = slash_q;
            if (b == ChSlash) begin
              slash_d = 1'b1;
            end else if (!is_space) begin
              emit_byte = 1'b1;
              if (b == ChQuote) mode_d = MODE_STR;
            end
          end
        end
      endcase
    end
    if (is_end) begin
      emit_end_slash = slash_d;
      emit_bare      = !slash_d && !emit_pre && !emit_byte;
      mode_d         = MODE_NORMAL;
      slash_d        = 1'b0;
    end
  end

  // Pack the results in order: released slash, byte, final slash, end marker.
  always_comb begin
    entry_o.byte0 = emit_pre ? ChSlash : (emit_byte ? b : (emit_end_slash ? ChSlash : ChNul));
    entry_o.has0  = !emit_bare;
    entry_o.byte1 = (emit_pre && emit_byte) ? b : ChSlash;
    entry_o.two   = (emit_pre && (emit_byte || emit_end_slash));
    entry_o.eot   = is_end;
  end

  assign push_o = fire_i && (emit_pre || emit_byte || emit_end_slash || emit_bare);

  // Lexer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      slash_q <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
    end
  end

  // A slash is only ever held in normal mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_q |-> (mode_q == MODE_NORMAL))
    else $error("slash held outside normal mode");

  // The end of a text always returns the lexer to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_end) |=> ((mode_q == MODE_NORMAL) && !slash_q))
    else $error("lexer state not cleared after end of text");

endmodule

// File: sv/jwcs_fifo.sv
`timescale 1ns / 1ps

module jwcs_fifo import jwcs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output head_t  head_o
);

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q;
  logic [QPtrW-1:0]   rd_ptr_q;
  logic [QCntW-1:0]   count_q;

  assign full_o       = (count_q == QCntW'(QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Never written when full, never read when empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !head_o.valid))
    else $error("queue overflow or underflow");

endmodule

// File: sv/jwcs_back.sv
`timescale 1ns / 1ps

module jwcs_back import jwcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  head_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic      idx_q;
  logic      out_valid_q;
  out_word_t out_q;
  out_word_t next_word;
  logic      is_final;
  logic      load;

  // Select the pending result of the head entry.
  assign is_final = !head_i.entry.two || idx_q;
  always_comb begin
    next_word.out_byte    = idx_q ? head_i.entry.byte1 : head_i.entry.byte0;
    next_word.has_byte    = idx_q ? 1'b1 : head_i.entry.has0;
    next_word.end_of_text = head_i.entry.eot && is_final;
    next_word.last_of_run = is_final;
  end

  assign load  = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_final;

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) out_q <= next_word;
  end

  // Result index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= !is_final;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The second result is only pending while its two-result entry heads the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (head_i.valid && head_i.entry.two))
    else $error("second result pending without a two-result entry");

endmodule

// File: sv/json_whitespace_comment_stripper.sv
`timescale 1ns / 1ps
// A word's first result passes through the queue and then the output register.
// Throughput: one word per cycle while out_ready_i is high and no word has two results;
// a word with two results gives them in turn and the input stalls once the queue fills.
// Reset: rst_ni is asynchronous and active low; it returns the lexer to normal mode
// with no slash held, empties the queue and drops the output valid.

module json_whitespace_comment_stripper import jwcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic   fire;
  logic   push;
  logic   pop;
  logic   full;
  entry_t entry;
  head_t  head;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  jwcs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .word_i  (in_data_i),
    .push_o  (push),
    .entry_o (entry)
  );

  jwcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .head_o  (head)
  );

  jwcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/json_whitespace_comment_stripper_tb.sv
`timescale 1ns / 1ps

module json_whitespace_comment_stripper_tb import jwcs_pkg::*; ();

  localparam int unsigned TextLen   = 1800;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainWait = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_word_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_word_t out_data;

  // Text bytes waiting to be sent, and minified words still expected.
  in_word_t  text_q[$];
  out_word_t minified_q[$];

  // Lexer state of the predictor.
  mode_e     lex_mode     = MODE_NORMAL;
  logic      slash_waits  = 1'b0;

  int unsigned err_cnt   = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cyc_cnt   = 0;
  int unsigned idle_cnt  = 0;
  int unsigned gap_cnt   = 0;
  int unsigned stall_cnt = 0;
  out_word_t   want_w;

  json_whitespace_comment_stripper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it.
  task automatic report_mismatch(string msg);
    if (err_cnt < 40) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  // Gap length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    if (r < 98) return $urandom_range(7, 15);
    return $urandom_range(30, 80);
  endfunction

  // One of the bytes the lexer treats specially, the zero byte excepted.
  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 7))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      3: return ChLf;
      4: return ChSlash;
      5: return ChStar;
      6: return ChBslash;
      default: return ChQuote;
    endcase
  endfunction

  // Nonzero byte for the body of a token, string or comment.
  function automatic logic [7:0] content_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h23, 8'h5B));
    if (r < 65) return 8'($urandom_range(8'h5D, 8'h7E));
    if (r < 90) return 8'($urandom_range(1, 255));
    return special_byte();
  endfunction

  task automatic push_byte(logic [7:0] b, logic l);
    in_word_t w;
    w.data_byte = b;
    w.last      = l;
    text_q = {text_q, w};
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], 1'b0);
    end
  endtask

  // Work out the minified words that one accepted text word yields.
  task automatic minify_word(in_word_t w);
    out_word_t   res[2];
    int unsigned n;
    logic [7:0]  b;
    logic        ends;
    logic        plain;
    n     = 0;
    b     = w.data_byte;
    ends  = (b == ChNul) || w.last;
    plain = 1'b0;
    res[0] = '0;
    res[1] = '0;
    if (b != ChNul) begin
      case (lex_mode)
        MODE_STR: begin
          res[n] = '{out_byte: b, has_byte: 1'b1, end_of_text: 1'b0, last_of_run: 1'b0};
          n++;
          if (b == ChBslash) lex_mode = MODE_STR_ESC;
          else if (b == ChQuote) lex_mode = MODE_NORMAL;
        end
        MODE_STR_ESC: begin
          res[n] = '{out_byte: b, has_byte: 1'b1, end_of_text: 1'b0, last_of_run: 1'b0};
          n++;
          lex_mode = MODE_STR;
        end
        MODE_LINE: begin
          if (b == ChLf) lex_mode = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (b == ChStar) lex_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == ChSlash) lex_mode = MODE_NORMAL;
          else if (b != ChStar) lex_mode = MODE_BLOCK;
        end
        default: begin
          lex_mode = MODE_NORMAL;
          if (slash_waits) begin
            slash_waits = 1'b0;
            if (b == ChSlash) begin
              lex_mode = MODE_LINE;
            end else if (b == ChStar) begin
              lex_mode = MODE_BLOCK;
            end else begin
              res[n] = '{out_byte: ChSlash, has_byte: 1'b1, end_of_text: 1'b0,
                         last_of_run: 1'b0};
              n++;
              plain = 1'b1;
            end
          end else begin
            plain = 1'b1;
          end
        end
      endcase
    end

    // Ordinary byte outside strings and comments.
    if (plain && !(b inside {ChSpace, ChTab, ChCr, ChLf})) begin
      if (b == ChSlash) begin
        slash_waits = 1'b1;
      end else begin
        res[n] = '{out_byte: b, has_byte: 1'b1, end_of_text: 1'b0, last_of_run: 1'b0};
        n++;
        if (b == ChQuote) lex_mode = MODE_STR;
      end
    end

    // End of text: flush a waiting slash or give a bare marker, then reset.
    if (ends) begin
      if (slash_waits) begin
        res[n] = '{out_byte: ChSlash, has_byte: 1'b1, end_of_text: 1'b0, last_of_run: 1'b0};
        n++;
      end else if (n == 0) begin
        res[n] = '0;
        n++;
      end
      res[n-1].end_of_text = 1'b1;
      lex_mode    = MODE_NORMAL;
      slash_waits = 1'b0;
    end

    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) begin
      minified_q = {minified_q, res[i]};
    end
  endtask

  // Driver: offers the next text word, with random gaps between words.
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      minify_word(in_data);
      sent_cnt++;
    end
    if (!in_valid || in_ready) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (rst_ni && text_q.size() > 0) begin
        in_data  <= text_q.pop_front();
        in_valid <= 1'b1;
        if ((sent_cnt % 400) >= 80 && $urandom_range(0, 99) < 30) begin
          gap_cnt = gap_len();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each minified word and stalls the output at random.
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (out_valid && out_ready) begin
      if (minified_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_data));
      end else begin
        want_w = minified_q.pop_front();
        if (out_data.out_byte !== want_w.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h", out_data.out_byte,
                                    want_w.out_byte));
        if (out_data.has_byte !== want_w.has_byte)
          report_mismatch($sformatf("has_byte %b, expected %b", out_data.has_byte,
                                    want_w.has_byte));
        if (out_data.end_of_text !== want_w.end_of_text)
          report_mismatch($sformatf("end_of_text %b, expected %b", out_data.end_of_text,
                                    want_w.end_of_text));
        if (out_data.last_of_run !== want_w.last_of_run)
          report_mismatch($sformatf("last_of_run %b, expected %b", out_data.last_of_run,
                                    want_w.last_of_run));
      end
    end
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ((cyc_cnt % 1500) >= 300 && $urandom_range(0, 99) < 25) begin
        stall_cnt = gap_len();
      end
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned kind;
    int unsigned len;

    // Directed text: whitespace, strings with an escaped quote, a plain slash,
    // both comment kinds, the opener star that must not close a block comment,
    // and the different ways a text can end.
    push_text(" \t\n");
    push_byte(ChCr, 1'b0);
    push_text("\"a\\\"b\"");
    push_text("/x");
    push_text("//c\n");
    push_text("/*/*/");
    push_byte(ChNul, 1'b0);
    push_byte(ChSlash, 1'b0);
    push_byte(ChNul, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(ChSlash, 1'b1);
    push_text("\"q");
    push_byte(ChNul, 1'b1);

    // Random text: mostly well-formed fragments, some noise and text ends.
    while (text_q.size() < TextLen) begin
      pick = $urandom_range(0, 9);
      len  = $urandom_range(0, 6);
      if (pick <= 5) begin
        kind = $urandom_range(0, 4);
        case (kind)
          0: begin
            push_byte(ChQuote, 1'b0);
            repeat (len) begin
              if ($urandom_range(0, 4) == 0) push_byte(ChBslash, 1'b0);
              push_byte(content_byte(), 1'b0);
            end
            push_byte(ChQuote, 1'b0);
          end
          1: begin
            push_text("//");
            repeat (len) push_byte(content_byte(), 1'b0);
            push_byte(ChLf, 1'b0);
          end
          2: begin
            push_text("/*");
            repeat (len) begin
              if ($urandom_range(0, 3) == 0) push_byte(ChStar, 1'b0);
              else push_byte(content_byte(), 1'b0);
            end
            push_text("*/");
          end
          3: begin
            repeat (len + 1) begin
              case ($urandom_range(0, 3))
                0: push_byte(ChSpace, 1'b0);
                1: push_byte(ChTab, 1'b0);
                2: push_byte(ChCr, 1'b0);
                default: push_byte(ChLf, 1'b0);
              endcase
            end
          end
          default: begin
            if ($urandom_range(0, 9) < 3) push_byte(ChSlash, 1'b0);
            repeat (len + 1) push_byte(content_byte(), 1'b0);
          end
        endcase
      end else if (pick <= 8) begin
        if ($urandom_range(0, 2) == 0) push_byte(special_byte(), $urandom_range(0, 49) == 0);
        else push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
      end else begin
        if ($urandom_range(0, 1) == 0) push_byte(ChNul, 1'($urandom_range(0, 1)));
        else push_byte(content_byte(), 1'b1);
      end
    end

    // Reset once, then let the driver run.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all text sent and every expected word seen.
    while (text_q.size() > 0 || in_valid || minified_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
    if (minified_q.size() > 0) begin
      report_mismatch($sformatf("%0d expected words never came", minified_q.size()));
    end

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
